@@ sv/hrv_pkg.sv @@
// Shared types, register codes and reset constants for the horizon row vote block.
// No dependencies; every other file but hrv_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hrv_pkg;

	localparam int ROW_COUNT_DEF  = 1024;
	localparam int COUNT_BITS_DEF = 16;

	localparam int ROW_W    = 10;
	localparam int WIN_W    = 6;
	localparam int WEIGHT_W = 16;
	localparam int SIZE_W   = 11;
	localparam int COORD_W  = 16;
	localparam int SCORE_W  = 32;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 3;
	// tap offsets reach +/-62, tap rows stay within -62..1085
	localparam int OFS_W    = WIN_W + 1;
	localparam int TAP_W    = ROW_W + 2;

	localparam logic MODE_POINT  = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	localparam logic [ROW_W-1:0]    FIRST_ROW_RST = 10'd26;
	localparam logic [ROW_W-1:0]    LAST_ROW_RST  = 10'd969;
	localparam logic [WIN_W-1:0]    OUTER_RST     = 6'd20;
	localparam logic [WIN_W-1:0]    INNER_RST     = 6'd10;
	localparam logic [WEIGHT_W-1:0] EXACT_RST     = 16'd1000;
	localparam logic [WEIGHT_W-1:0] NEAR_RST      = 16'd100;
	localparam logic [WEIGHT_W-1:0] FAR_RST       = 16'd40;
	localparam logic [SIZE_W-1:0]   SIZE_RST      = 11'd1000;

	typedef enum logic [IDX_W-1:0] {
		REG_FIRST_ROW = 3'd0,
		REG_LAST_ROW  = 3'd1,
		REG_OUTER     = 3'd2,
		REG_INNER     = 3'd3,
		REG_EXACT     = 3'd4,
		REG_NEAR      = 3'd5,
		REG_FAR       = 3'd6,
		REG_SIZE      = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POINT,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic                      mode;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]   best_row;
		logic [SIZE_W-1:0]  horizon_row;
		logic [SCORE_W-1:0] best_score;
	} out_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]    first_row;
		logic [ROW_W-1:0]    last_row;
		logic [WIN_W-1:0]    outer_half_window;
		logic [WIN_W-1:0]    inner_half_window;
		logic [WEIGHT_W-1:0] exact_weight;
		logic [WEIGHT_W-1:0] near_weight;
		logic [WEIGHT_W-1:0] far_weight;
		logic [SIZE_W-1:0]   image_size;
	} cfg_t;

	// one window tap issued to the multiply-accumulate unit
	typedef struct packed {
		logic                valid;
		logic                last;   // final tap of its row
		logic                hit;    // tap row lies inside the store
		logic [WEIGHT_W-1:0] weight;
		logic [ROW_W-1:0]    row;
	} tap_t;

	typedef struct packed {
		logic               valid;
		logic [ROW_W-1:0]   row;
		logic [SCORE_W-1:0] score;
	} row_score_t;

endpackage

`default_nettype wire

@@ sv/hrv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hrv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/hrv_mac.sv @@
// Shared multiply-accumulate unit: weights one row count per cycle and sums a row's taps.
// Depends on hrv_pkg; count data arrives from hrv_ram in the cycle after the tap is issued.
`timescale 1ns / 1ps
`default_nettype none

module hrv_mac #(
	parameter int COUNT_BITS = hrv_pkg::COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire hrv_pkg::tap_t         tap,
	input  wire logic [COUNT_BITS-1:0] count,
	output hrv_pkg::row_score_t        row_score,
	output logic                       busy
);

	import hrv_pkg::*;

	localparam int PROD_W = COUNT_BITS + WEIGHT_W;
	localparam int SUM_W  = ((PROD_W > SCORE_W) ? PROD_W : SCORE_W) + 1;

	tap_t               tap_s1;
	logic               valid_s2;
	logic               last_s2;
	logic [ROW_W-1:0]   row_s2;
	logic [PROD_W-1:0]  prod_s2;
	logic [SCORE_W-1:0] acc_q;
	logic               score_valid_s3;
	logic [ROW_W-1:0]   score_row_s3;
	logic [SCORE_W-1:0] score_sum_s3;

	logic [SUM_W-1:0]   sum;
	logic [SCORE_W-1:0] sum_sat;

	always_comb begin
		sum     = SUM_W'(acc_q) + SUM_W'(prod_s2);
		sum_sat = (|sum[SUM_W-1:SCORE_W]) ? '1 : sum[SCORE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1         <= '0;
			valid_s2       <= 1'b0;
			last_s2        <= 1'b0;
			acc_q          <= '0;
			score_valid_s3 <= 1'b0;
		end else begin
			tap_s1   <= tap;
			valid_s2 <= tap_s1.valid;
			last_s2  <= tap_s1.last;
			score_valid_s3 <= valid_s2 && last_s2;
			if (valid_s2) begin
				acc_q <= last_s2 ? '0 : sum_sat;
			end
		end
	end

	// taps outside the store contribute nothing
	always_ff @(posedge clk) begin
		row_s2  <= tap_s1.row;
		prod_s2 <= tap_s1.hit ? PROD_W'(count) * PROD_W'(tap_s1.weight) : '0;
		if (valid_s2 && last_s2) begin
			score_row_s3 <= row_s2;
			score_sum_s3 <= sum_sat;
		end
	end

	assign row_score = '{valid: score_valid_s3, row: score_row_s3, score: score_sum_s3};
	assign busy      = tap_s1.valid || valid_s2 || score_valid_s3;

endmodule

`default_nettype wire

@@ sv/horizon_row_vote_top.sv @@
// Horizon row vote: top level with sequencer, configuration registers and result register.
// Depends on hrv_pkg, hrv_ram (row count store) and hrv_mac (tap weighting unit).
`timescale 1ns / 1ps
`default_nettype none

// A point transaction (mode 0) reads its row count in the store and, in ST_POINT, writes
// it back with a saturating increment; a point not strictly inside the image is dropped.
// A finish transaction (mode 1) walks rows first_row..min(last_row, ROW_COUNT-1) and,
// per row, the 2*outer_half_window-1 window taps, one tap per cycle through the single
// RAM read port and the shared multiplier, then waits for the pipeline to drain.
// The result is then parked in the output register and the store is swept back to zero,
// one row per cycle, before the next item is taken. The same clearing pass runs after
// reset. Configuration writes are taken at any time (cfg_ready is always high) but must
// only be issued while the block is idle.

module horizon_row_vote_top #(
	parameter int ROW_COUNT  = hrv_pkg::ROW_COUNT_DEF,
	parameter int COUNT_BITS = hrv_pkg::COUNT_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	output logic                           item_ready,
	input  wire hrv_pkg::in_item_t         item,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output hrv_pkg::out_item_t             result,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [hrv_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [hrv_pkg::CFG_W-1:0] cfg_data
);

	import hrv_pkg::*;

	localparam int AW = $clog2(ROW_COUNT);

	state_t state_q, state_d;
	cfg_t   cfg_q;

	logic [AW-1:0]         clr_q;
	logic [AW-1:0]         pt_addr_q;
	logic [ROW_W-1:0]      row_q;
	logic signed [OFS_W-1:0] ofs_q;
	logic [SCORE_W-1:0]    max_score_q;
	logic [ROW_W-1:0]      max_row_q;
	logic                  res_valid_q;
	out_item_t             res_q;

	// combinational
	logic                  accept;
	logic                  point_ok;
	logic [ROW_W-1:0]      last_end;
	logic                  scan_empty;
	logic signed [OFS_W-1:0] ofs_first;
	logic signed [OFS_W-1:0] ofs_last;
	logic [OFS_W-1:0]      ofs_abs;
	logic signed [TAP_W-1:0] tap_row;
	logic                  tap_last;
	logic                  clr_done;
	logic                  load_result;
	tap_t                  tap;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [COUNT_BITS-1:0] rd_data;
	row_score_t            row_score;
	logic                  mac_busy;

	assign accept    = item_valid && item_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		point_ok = (item.point_x > 0)
			&& (item.point_x < $signed({5'b0, cfg_q.image_size}))
			&& (item.point_y > 0)
			&& (item.point_y < $signed({5'b0, cfg_q.image_size}))
			&& (int'(item.point_y) < ROW_COUNT);
		last_end = (int'(cfg_q.last_row) >= ROW_COUNT) ? ROW_W'(ROW_COUNT - 1)
			: cfg_q.last_row;
		scan_empty = (cfg_q.outer_half_window == '0) || (cfg_q.first_row > last_end);
		ofs_first  = $signed(OFS_W'(1)) - $signed({1'b0, cfg_q.outer_half_window});
		ofs_last   = $signed({1'b0, cfg_q.outer_half_window}) - $signed(OFS_W'(1));
		ofs_abs    = ofs_q[OFS_W-1] ? OFS_W'(-ofs_q) : OFS_W'(ofs_q);
		tap_row    = $signed({2'b0, row_q}) + TAP_W'(ofs_q);
		tap_last   = (ofs_q == ofs_last);
		clr_done   = (clr_q == AW'(ROW_COUNT - 1));
		load_result = (state_q == ST_RESULT) && (!res_valid_q || result_ready);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (item.mode == MODE_FINISH) begin
						state_d = scan_empty ? ST_RESULT : ST_SCAN;
					end else if (point_ok) begin
						state_d = ST_POINT;
					end
				end
			end
			ST_POINT: state_d = ST_IDLE;
			ST_SCAN: begin
				if (tap_last && (row_q == last_end)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!mac_busy) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (load_result) state_d = ST_CLEAR;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item_ready = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = AW'($unsigned(item.point_y));
		wr_en      = 1'b0;
		wr_addr    = clr_q;
		wr_data    = '0;
		tap        = '0;
		tap.row    = row_q;
		tap.last   = tap_last;
		tap.hit    = !tap_row[TAP_W-1] && (int'(tap_row) < ROW_COUNT);
		if (ofs_abs == '0) begin
			tap.weight = cfg_q.exact_weight;
		end else if (ofs_abs < {1'b0, cfg_q.inner_half_window}) begin
			tap.weight = cfg_q.near_weight;
		end else begin
			tap.weight = cfg_q.far_weight;
		end
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				rd_en      = item_valid && (item.mode == MODE_POINT) && point_ok;
			end
			ST_POINT: begin
				wr_en   = 1'b1;
				wr_addr = pt_addr_q;
				wr_data = (&rd_data) ? rd_data : rd_data + COUNT_BITS'(1);
			end
			ST_SCAN: begin
				tap.valid = 1'b1;
				rd_en     = tap.hit;
				rd_addr   = AW'($unsigned(tap_row));
			end
			ST_DRAIN, ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			row_q       <= '0;
			ofs_q       <= '0;
			max_score_q <= '0;
			max_row_q   <= '0;
			res_valid_q <= 1'b0;
			cfg_q       <= '{FIRST_ROW_RST, LAST_ROW_RST, OUTER_RST, INNER_RST,
				EXACT_RST, NEAR_RST, FAR_RST, SIZE_RST};
		end else begin
			state_q <= state_d;

			if (state_q == ST_CLEAR) begin
				clr_q <= clr_done ? '0 : clr_q + AW'(1);
			end

			if (accept && (item.mode == MODE_FINISH)) begin
				row_q       <= cfg_q.first_row;
				ofs_q       <= ofs_first;
				max_score_q <= '0;
				max_row_q   <= '0;
			end else if (state_q == ST_SCAN) begin
				if (tap_last) begin
					row_q <= row_q + ROW_W'(1);
					ofs_q <= ofs_first;
				end else begin
					ofs_q <= ofs_q + OFS_W'(1);
				end
			end

			// rows finish in order, so a strict compare keeps the first best row
			if (row_score.valid && (row_score.score > max_score_q)) begin
				max_score_q <= row_score.score;
				max_row_q   <= row_score.row;
			end

			if (load_result) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_FIRST_ROW: cfg_q.first_row         <= cfg_data[ROW_W-1:0];
					REG_LAST_ROW:  cfg_q.last_row          <= cfg_data[ROW_W-1:0];
					REG_OUTER:     cfg_q.outer_half_window <= cfg_data[WIN_W-1:0];
					REG_INNER:     cfg_q.inner_half_window <= cfg_data[WIN_W-1:0];
					REG_EXACT:     cfg_q.exact_weight      <= cfg_data[WEIGHT_W-1:0];
					REG_NEAR:      cfg_q.near_weight       <= cfg_data[WEIGHT_W-1:0];
					REG_FAR:       cfg_q.far_weight        <= cfg_data[WEIGHT_W-1:0];
					REG_SIZE:      cfg_q.image_size        <= cfg_data[SIZE_W-1:0];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pt_addr_q <= AW'($unsigned(item.point_y));
		end
		if (load_result) begin
			res_q.best_row    <= max_row_q;
			res_q.horizon_row <= cfg_q.image_size - {1'b0, max_row_q};
			res_q.best_score  <= max_score_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	hrv_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (ROW_COUNT)
	) u_counts (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	hrv_mac #(
		.COUNT_BITS (COUNT_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.tap       (tap),
		.count     (rd_data),
		.row_score (row_score),
		.busy      (mac_busy)
	);

endmodule

`default_nettype wire

@@ sv/hrv_checker.sv @@
// Port-level checks for horizon_row_vote_top, attached by the bind at the end of this file.
// Depends on hrv_pkg for the transaction payload types.
`timescale 1ns / 1ps
`default_nettype none

module hrv_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      item_valid,
	input wire logic                      item_ready,
	input wire hrv_pkg::in_item_t         item,
	input wire logic                      result_valid,
	input wire logic                      result_ready,
	input wire hrv_pkg::out_item_t        result
);

	import hrv_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// no positive score means row zero
	a_zero_score_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.best_score == '0) |-> (result.best_row == '0))
		else $error("nonzero best row with zero score");

	// a finish transaction always leaves the block not ready in the cycle after it is taken
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.mode == MODE_FINISH) |=> !item_ready)
		else $error("ready right after a finish transaction");

	// a new result is followed by the store clearing pass
	a_result_then_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !item_ready)
		else $error("ready while the count store is being cleared");

endmodule

bind horizon_row_vote_top hrv_checker u_hrv_checker (.*);

`default_nettype wire
